// ===== rtl/core/ectk_pkg.sv =====
// Shared constants and types for the encoder count tracker.
`default_nettype none

package ectk_pkg;

    // Number of encoder channels kept in the state memory.
    localparam int CHANNELS = 2;
    // Width of the channel field and of the memory address.
    localparam int CH_W     = 1;
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 64;

    localparam logic [DATA_W-1:0] POSITION_GAIN_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] PERIOD_GAIN_RESET   = 32'h0000_0001;

    typedef logic [CH_W-1:0] chan_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_POSITION_GAIN = 1'b0,
        REG_PERIOD_GAIN   = 1'b1
    } cfg_reg_t;

    // One accepted input item.
    typedef struct packed {
        chan_t              channel;
        logic               operational;
        logic [DATA_W-1:0]  raw_counter;
        logic [DATA_W-1:0]  raw_period_in;
        logic               set_done;
        logic               index_pulse;
        logic               index_enable_in;
        logic               count_reset;
        logic               set_request_in;
    } item_t;

    // Per-channel state word held in the state memory.
    typedef struct packed {
        logic [DATA_W-1:0]  prev_raw_count;
        logic [DATA_W-1:0]  running_count;
        logic               prev_index_level;
        logic               needs_init;
        logic [DATA_W-1:0]  held_raw_count;
        logic [DATA_W-1:0]  held_raw_period;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        prev_raw_count:   '0,
        running_count:    '0,
        prev_index_level: 1'b0,
        needs_init:       1'b1,
        held_raw_count:   '0,
        held_raw_period:  '0
    };

    // Result fields before scaling.
    typedef struct packed {
        chan_t              channel;
        logic [DATA_W-1:0]  hold_count;
        logic [DATA_W-1:0]  hold_period;
        logic [DATA_W-1:0]  net_count;
        logic               set_request_next;
        logic               index_enable_next;
    } result_t;

    // Control produced by the update logic for one item.
    typedef struct packed {
        logic commit;
        logic was_op_next;
    } update_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ectk_if.sv =====
// Channel interfaces for the encoder count tracker: input, result and configuration.
`default_nettype none

interface ectk_in_if;
    logic                           valid;
    logic                           ready;
    ectk_pkg::chan_t                channel;
    logic                           operational;
    logic signed [31:0]             raw_counter;
    logic [31:0]                    raw_period_in;
    logic                           set_done;
    logic                           index_pulse;
    logic                           index_enable_in;
    logic                           count_reset;
    logic                           set_request_in;

    modport source (
        output valid, channel, operational, raw_counter, raw_period_in, set_done,
               index_pulse, index_enable_in, count_reset, set_request_in,
        input  ready
    );
    modport sink (
        input  valid, channel, operational, raw_counter, raw_period_in, set_done,
               index_pulse, index_enable_in, count_reset, set_request_in,
        output ready
    );
endinterface

interface ectk_out_if;
    logic                           valid;
    logic                           ready;
    ectk_pkg::chan_t                channel_out;
    logic signed [31:0]             raw_count_out;
    logic [31:0]                    raw_period_out;
    logic signed [31:0]             net_count;
    logic signed [63:0]             position;
    logic [63:0]                    period_value;
    logic                           set_request_next;
    logic                           index_enable_next;

    modport source (
        output valid, channel_out, raw_count_out, raw_period_out, net_count, position,
               period_value, set_request_next, index_enable_next,
        input  ready
    );
    modport sink (
        input  valid, channel_out, raw_count_out, raw_period_out, net_count, position,
               period_value, set_request_next, index_enable_next,
        output ready
    );
endinterface

interface ectk_cfg_if;
    logic                           valid;
    logic                           ready;
    ectk_pkg::cfg_reg_t             index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ectk_state_mem.sv =====
// Per-channel state memory with registered read, valid bits and write forwarding.
`default_nettype none

module ectk_state_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire ectk_pkg::chan_t   rd_addr,
    input  wire logic              wr_en,
    input  wire ectk_pkg::chan_t   wr_addr,
    input  wire ectk_pkg::entry_t  wr_data,
    output ectk_pkg::entry_t       rd_data
);

    ectk_pkg::entry_t                   mem [ectk_pkg::CHANNELS];
    logic [ectk_pkg::CHANNELS-1:0]      valid_reg;
    ectk_pkg::entry_t                   q_reg;
    ectk_pkg::entry_t                   byp_reg;
    logic                               rd_valid_reg;
    logic                               byp_hit_reg;

    // Storage array and read port; the write data is captured for forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg   <= mem[rd_addr];
            byp_reg <= wr_data;
        end
    end

    // Valid bits and read qualifiers; an entry never written reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // A read at the same edge as a write to that entry takes the written word.
    always_comb
    begin
        if (byp_hit_reg)
        begin
            rd_data = byp_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data = ectk_pkg::ENTRY_RESET;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ectk_update.sv =====
// Read-modify-write logic: next channel state, unscaled result and control for one item.
`default_nettype none

module ectk_update (
    input  wire ectk_pkg::item_t    item,
    input  wire ectk_pkg::entry_t   entry,
    input  wire logic               was_op,
    output ectk_pkg::entry_t        entry_next,
    output ectk_pkg::result_t       result,
    output ectk_pkg::update_ctl_t   ctl
);

    logic                           in_range;
    logic                           last_ch;
    logic                           set_req;
    logic                           idx_rise;
    logic                           init;
    logic                           take;
    logic                           reload;
    logic [ectk_pkg::DATA_W-1:0]    delta;
    logic [ectk_pkg::DATA_W-1:0]    base;

    assign in_range = int'(item.channel) < ectk_pkg::CHANNELS;
    assign last_ch  = item.channel == ectk_pkg::CH_W'(ectk_pkg::CHANNELS - 1);

    // Request and edge decisions.
    always_comb
    begin
        set_req  = item.set_request_in & ~item.set_done;
        idx_rise = item.index_pulse & ~entry.prev_index_level;
        init     = entry.needs_init | item.count_reset;
        take     = idx_rise & ~init & item.index_enable_in;
        // Any reload of the previous raw count makes this item's difference zero.
        reload   = ~was_op | item.set_done | init | take;
        delta    = reload ? '0 : (item.raw_counter - entry.prev_raw_count);
        base     = (init | take) ? '0 : entry.running_count;
    end

    // New state word.
    always_comb
    begin
        entry_next                  = entry;
        entry_next.prev_raw_count   = item.raw_counter;
        entry_next.running_count    = base + delta;
        entry_next.prev_index_level = item.index_pulse;
        entry_next.needs_init       = 1'b0;
        if (!set_req)
        begin
            entry_next.held_raw_count  = item.raw_counter;
            entry_next.held_raw_period = item.raw_period_in;
        end
    end

    // Result fields and control.
    always_comb
    begin
        result.channel           = item.channel;
        result.hold_count        = entry_next.held_raw_count;
        result.hold_period       = entry_next.held_raw_period;
        result.net_count         = entry_next.running_count;
        result.set_request_next  = set_req;
        result.index_enable_next = item.index_enable_in & ~take;

        ctl.commit = item.operational & in_range;
        if (!item.operational)
        begin
            ctl.was_op_next = 1'b0;
        end
        else if (in_range && last_ch)
        begin
            ctl.was_op_next = 1'b1;
        end
        else
        begin
            ctl.was_op_next = was_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ectk_scale.sv =====
// Scaling stage and result register: position and period products with output handshake.
`default_nettype none

module ectk_scale (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire ectk_pkg::result_t              result_in,
    output logic                                can_load,
    input  wire logic [ectk_pkg::DATA_W-1:0]    position_gain,
    input  wire logic [ectk_pkg::DATA_W-1:0]    period_gain,
    ectk_out_if.source                          out_ch
);

    logic                           s2_v_reg;
    ectk_pkg::result_t              s2_reg;
    logic                           out_v_reg;
    ectk_pkg::result_t              out_reg;
    logic signed [ectk_pkg::PROD_W-1:0] pos_prod;
    logic [ectk_pkg::PROD_W-1:0]    per_prod;
    logic signed [ectk_pkg::PROD_W-1:0] pos_reg;
    logic [ectk_pkg::PROD_W-1:0]    per_reg;
    logic                           adv_out;

    assign adv_out  = !out_v_reg || out_ch.ready;
    assign can_load = !s2_v_reg || adv_out;

    // One signed and one unsigned 32 by 32 product, registered in the result stage.
    assign pos_prod = $signed(s2_reg.net_count) * $signed(position_gain);
    assign per_prod = s2_reg.hold_period * period_gain;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_out)
            begin
                out_v_reg <= s2_v_reg;
            end
            if (can_load)
            begin
                s2_v_reg <= load;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            s2_reg <= result_in;
        end
        if (adv_out && s2_v_reg)
        begin
            out_reg <= s2_reg;
            pos_reg <= pos_prod;
            per_reg <= per_prod;
        end
    end

    assign out_ch.valid             = out_v_reg;
    assign out_ch.channel_out       = out_reg.channel;
    assign out_ch.raw_count_out     = $signed(out_reg.hold_count);
    assign out_ch.raw_period_out    = out_reg.hold_period;
    assign out_ch.net_count         = $signed(out_reg.net_count);
    assign out_ch.position          = pos_reg;
    assign out_ch.period_value      = per_reg;
    assign out_ch.set_request_next  = out_reg.set_request_next;
    assign out_ch.index_enable_next = out_reg.index_enable_next;

endmodule

`default_nettype wire

// ===== rtl/core/encoder_count_tracker_index.sv =====
// Encoder count tracker top level: state memory, update stage, scaling stage and config.
// Path: each result passes the memory read and update stage, the scaling stage and the
// result register after its item's transaction, held only while the result side stalls.
// Throughput: one item per cycle unless results stall, including back-to-back items on
// one channel via state memory write forwarding; a non-operational item takes one slot.
// Reset: the gains return to 1.0 and 1, all channels read as uninitialized through
// their valid bits at once, and no clearing pass is needed.
`default_nettype none

module encoder_count_tracker_index (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ectk_cfg_if.sink    cfg,
    ectk_in_if.sink     in_ch,
    ectk_out_if.source  out_ch
);

    logic [ectk_pkg::DATA_W-1:0]    position_gain_reg;
    logic [ectk_pkg::DATA_W-1:0]    period_gain_reg;
    logic                           was_op_reg;
    logic                           s1_v_reg;
    ectk_pkg::item_t                s1_item_reg;
    ectk_pkg::item_t                in_item;
    ectk_pkg::entry_t               rd_entry;
    ectk_pkg::entry_t               entry_next;
    ectk_pkg::result_t              result;
    ectk_pkg::update_ctl_t          ctl;
    logic                           s2_can_load;
    logic                           s1_go;
    logic                           s1_load;
    logic                           in_fire;
    logic                           mem_wr;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_gain_reg <= ectk_pkg::POSITION_GAIN_RESET;
            period_gain_reg   <= ectk_pkg::PERIOD_GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ectk_pkg::REG_POSITION_GAIN: position_gain_reg <= cfg.data;
                ectk_pkg::REG_PERIOD_GAIN:   period_gain_reg   <= cfg.data;
            endcase
        end
    end

    // Input item packing.
    always_comb
    begin
        in_item.channel         = in_ch.channel;
        in_item.operational     = in_ch.operational;
        in_item.raw_counter     = in_ch.raw_counter;
        in_item.raw_period_in   = in_ch.raw_period_in;
        in_item.set_done        = in_ch.set_done;
        in_item.index_pulse     = in_ch.index_pulse;
        in_item.index_enable_in = in_ch.index_enable_in;
        in_item.count_reset     = in_ch.count_reset;
        in_item.set_request_in  = in_ch.set_request_in;
    end

    // Update stage handshake: items without a result leave without waiting.
    assign s1_go        = s1_v_reg && (!ctl.commit || s2_can_load);
    assign s1_load      = !s1_v_reg || s1_go;
    assign in_ch.ready  = s1_load;
    assign in_fire      = in_ch.valid && s1_load;
    assign mem_wr       = s1_go && ctl.commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            was_op_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_v_reg <= in_ch.valid;
            end
            if (s1_go)
            begin
                was_op_reg <= ctl.was_op_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
    end

    // State memory: read on acceptance, written back when the update stage retires.
    ectk_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (in_item.channel),
        .wr_en   (mem_wr),
        .wr_addr (s1_item_reg.channel),
        .wr_data (entry_next),
        .rd_data (rd_entry)
    );

    ectk_update u_update (
        .item       (s1_item_reg),
        .entry      (rd_entry),
        .was_op     (was_op_reg),
        .entry_next (entry_next),
        .result     (result),
        .ctl        (ctl)
    );

    ectk_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (mem_wr),
        .result_in     (result),
        .can_load      (s2_can_load),
        .position_gain (position_gain_reg),
        .period_gain   (period_gain_reg),
        .out_ch        (out_ch)
    );

    // An item read at the edge its channel is written sees the written state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mem_wr && (in_item.channel == s1_item_reg.channel)
        |=> rd_entry == $past(entry_next))
        else $error("state forwarding lost a same-channel write");

    // A non-operational item leaves the operational flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && !s1_item_reg.operational |=> !was_op_reg)
        else $error("operational flag not cleared");

    // A held update stage accepts no new item.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_go |-> !in_ch.ready)
        else $error("input accepted while update stage is held");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the encoder count tracker: stimulus, prediction and result checks.

module tb_top;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 500;
    localparam int PHASE_ITEMS   = 305;
    localparam int PHASES        = 6;

    // One result as seen on the output channel.
    typedef struct packed {
        ectk_pkg::chan_t channel;
        logic [31:0]  hold_count;
        logic [31:0]  hold_period;
        logic [31:0]  net_count;
        logic [63:0]  position;
        logic [63:0]  period_value;
        logic         set_request;
        logic         index_enable;
    } reading_t;

    logic clk;
    logic rst_n;

    ectk_in_if  in_if ();
    ectk_out_if out_if ();
    ectk_cfg_if cfg_if ();

    encoder_count_tracker_index u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    // Stimulus and expected readings.
    ectk_pkg::item_t items_to_send [$];
    reading_t expected_readings [$];
    ectk_pkg::item_t on_wire;
    reading_t predicted;
    logic     offering;
    int       mismatches = 0;

    // Idle rates in percent and the long receiver hold-off.
    int       send_idle_pct = 8;
    int       recv_idle_pct = 61;
    logic     hold_go = 1'b0;
    logic     rx_hold = 1'b0;

    // Tracker state mirrored by the predictor.
    logic [31:0] pos_gain;
    logic [31:0] per_gain;
    logic [31:0] last_raw [ectk_pkg::CHANNELS];
    logic [31:0] net [ectk_pkg::CHANNELS];
    logic        prev_level [ectk_pkg::CHANNELS];
    logic        uninit [ectk_pkg::CHANNELS];
    logic [31:0] held_count [ectk_pkg::CHANNELS];
    logic [31:0] held_period [ectk_pkg::CHANNELS];
    logic        was_op;

    // Generator state so raw counters move like a real encoder.
    logic [31:0] gen_raw [ectk_pkg::CHANNELS];
    logic        gen_index [ectk_pkg::CHANNELS];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the reading that one accepted transaction produces, if any.
    function automatic bit predict_reading(input ectk_pkg::item_t it, output reading_t r);
        int          c;
        logic        rise;
        logic        req;
        logic        ena;
        logic [31:0] raw;
        r = '0;
        if (!it.operational)
        begin
            was_op = 1'b0;
            return 1'b0;
        end
        c = it.channel;
        if (c >= ectk_pkg::CHANNELS)
            return 1'b0;
        raw = it.raw_counter;
        req = it.set_request_in;
        ena = it.index_enable_in;

        // Coming back to operation reloads the previous count, so the gap adds nothing.
        if (!was_op)
            last_raw[c] = raw;
        if (it.set_done)
        begin
            last_raw[c] = raw;
            req = 1'b0;
        end
        if (!req)
        begin
            held_count[c]  = raw;
            held_period[c] = it.raw_period_in;
        end

        rise = it.index_pulse && !prev_level[c];
        prev_level[c] = it.index_pulse;

        // First use or a count reset zeroes the count and masks the index edge.
        if (uninit[c] || it.count_reset)
        begin
            uninit[c]   = 1'b0;
            last_raw[c] = raw;
            net[c]      = '0;
            rise        = 1'b0;
        end
        if (rise && ena)
        begin
            last_raw[c] = raw;
            net[c]      = '0;
            ena         = 1'b0;
        end

        net[c] = net[c] + raw - last_raw[c];
        last_raw[c] = raw;
        if (c == ectk_pkg::CHANNELS - 1)
            was_op = 1'b1;

        r.channel      = ectk_pkg::chan_t'(c);
        r.hold_count   = held_count[c];
        r.hold_period  = held_period[c];
        r.net_count    = net[c];
        r.position     = $signed(net[c]) * $signed(pos_gain);
        r.period_value = 64'(held_period[c]) * 64'(per_gain);
        r.set_request  = req;
        r.index_enable = ena;
        return 1'b1;
    endfunction

    function automatic ectk_pkg::item_t directed_item(input ectk_pkg::chan_t ch,
                                            input logic [31:0] raw,
                                            input logic [31:0] per, input logic done,
                                            input logic idx, input logic ena,
                                            input logic clr, input logic req);
        ectk_pkg::item_t it;
        it = '{ch, 1'b1, raw, per, done, idx, ena, clr, req};
        return it;
    endfunction

    // Operational item for one channel: mostly small moves, sometimes wraps and jumps.
    function automatic ectk_pkg::item_t random_item(input int ch);
        ectk_pkg::item_t it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            gen_raw[ch] = gen_raw[ch] + $urandom_range(64) - 32;
        else if (pick < 85)
            gen_raw[ch] = gen_raw[ch] + $urandom;
        else if (pick < 92)
            gen_raw[ch] = 32'h7FFF_FFF0 + $urandom_range(31);
        else
            gen_raw[ch] = $urandom;
        if ($urandom_range(3) == 0)
            gen_index[ch] = ~gen_index[ch];
        it.channel         = ectk_pkg::chan_t'(ch);
        it.operational     = 1'b1;
        it.raw_counter     = gen_raw[ch];
        it.raw_period_in   = $urandom_range(1) ? $urandom : $urandom_range(1000);
        it.set_done        = ($urandom_range(9) == 0);
        it.index_pulse     = gen_index[ch];
        it.index_enable_in = ($urandom_range(2) == 0);
        it.count_reset     = ($urandom_range(24) == 0);
        it.set_request_in  = ($urandom_range(3) == 0);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 100)
            $display("MISMATCH at %0t on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Register write; the predictor takes the new value once the transaction completes.
    task automatic write_reg(input ectk_pkg::cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            ectk_pkg::REG_POSITION_GAIN: pos_gain = value;
            ectk_pkg::REG_PERIOD_GAIN:   per_gain = value;
            default:           ;
        endcase
    endtask

    // Wait until everything sent has been answered, then let the pipeline settle.
    task automatic wait_idle();
        while (items_to_send.size() != 0 || offering || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: predicts each completed transaction and offers the next item.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        int c;
        if (!rst_n)
        begin
            in_if.valid           <= 1'b0;
            in_if.channel         <= '0;
            in_if.operational     <= 1'b0;
            in_if.raw_counter     <= '0;
            in_if.raw_period_in   <= '0;
            in_if.set_done        <= 1'b0;
            in_if.index_pulse     <= 1'b0;
            in_if.index_enable_in <= 1'b0;
            in_if.count_reset     <= 1'b0;
            in_if.set_request_in  <= 1'b0;
            offering = 1'b0;
            pos_gain = ectk_pkg::POSITION_GAIN_RESET;
            per_gain = ectk_pkg::PERIOD_GAIN_RESET;
            was_op   = 1'b0;
            for (c = 0; c < ectk_pkg::CHANNELS; c++)
            begin
                last_raw[c]    = '0;
                net[c]         = '0;
                prev_level[c]  = 1'b0;
                uninit[c]      = 1'b1;
                held_count[c]  = '0;
                held_period[c] = '0;
            end
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                if (predict_reading(on_wire, predicted))
                    expected_readings.push_back(predicted);
                offering = 1'b0;
            end
            if (!offering && items_to_send.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
            begin
                on_wire  = items_to_send.pop_front();
                offering = 1'b1;
                in_if.channel         <= on_wire.channel;
                in_if.operational     <= on_wire.operational;
                in_if.raw_counter     <= on_wire.raw_counter;
                in_if.raw_period_in   <= on_wire.raw_period_in;
                in_if.set_done        <= on_wire.set_done;
                in_if.index_pulse     <= on_wire.index_pulse;
                in_if.index_enable_in <= on_wire.index_enable_in;
                in_if.count_reset     <= on_wire.count_reset;
                in_if.set_request_in  <= on_wire.set_request_in;
            end
            in_if.valid <= offering;
        end
    end

    // Output monitor: checks each completed transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        reading_t seen;
        reading_t want;
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                seen = '{out_if.channel_out, out_if.raw_count_out, out_if.raw_period_out,
                         out_if.net_count, out_if.position, out_if.period_value,
                         out_if.set_request_next, out_if.index_enable_next};
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected result, net_count", seen.net_count, '0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (seen.channel !== want.channel)
                        report_mismatch("channel_out", seen.channel, want.channel);
                    if (seen.hold_count !== want.hold_count)
                        report_mismatch("raw_count_out", seen.hold_count, want.hold_count);
                    if (seen.hold_period !== want.hold_period)
                        report_mismatch("raw_period_out", seen.hold_period, want.hold_period);
                    if (seen.net_count !== want.net_count)
                        report_mismatch("net_count", seen.net_count, want.net_count);
                    if (seen.position !== want.position)
                        report_mismatch("position", seen.position, want.position);
                    if (seen.period_value !== want.period_value)
                        report_mismatch("period_value", seen.period_value, want.period_value);
                    if (seen.set_request !== want.set_request)
                        report_mismatch("set_request_next", seen.set_request,
                                        want.set_request);
                    if (seen.index_enable !== want.index_enable)
                        report_mismatch("index_enable_next", seen.index_enable,
                                        want.index_enable);
                end
            end
            out_if.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering items.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Stimulus: reset, directed cases, then random phases over several gain settings.
    initial
    begin : stimulus
        ectk_pkg::item_t it;
        int          count;
        int          p;
        logic [31:0] pg;
        logic [31:0] qg;

        rst_n                 = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = ectk_pkg::REG_POSITION_GAIN;
        cfg_if.data           = '0;
        for (p = 0; p < ectk_pkg::CHANNELS; p++)
        begin
            gen_raw[p]   = '0;
            gen_index[p] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset gains.
        // First use with an index edge present: the edge is ignored and the enable stays.
        items_to_send.push_back(directed_item(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 0, 0));
        // First use on the other channel with set done clearing the request.
        items_to_send.push_back(directed_item(1, 32'h8000_0000, 32'h0, 1, 0, 0, 0, 1));
        // Signed wrap of the raw counter counts as a step of one.
        items_to_send.push_back(directed_item(0, 32'h8000_0000, 32'h1, 0, 1, 1, 0, 0));
        items_to_send.push_back(directed_item(0, 32'h8000_0010, 32'h2, 0, 0, 1, 0, 0));
        // Rising index edge with the enable set takes the index.
        items_to_send.push_back(directed_item(0, 32'h8000_0020, 32'h3, 0, 1, 1, 0, 0));
        // Index edge without enable, counting backward across the wrap.
        items_to_send.push_back(directed_item(1, 32'h7FFF_FFFF, 32'h4, 0, 1, 0, 0, 0));
        // Count reset.
        items_to_send.push_back(directed_item(0, 32'h1234_5678, 32'h5, 0, 0, 0, 1, 0));
        // Pending set request holds the raw outputs.
        items_to_send.push_back(directed_item(0, 32'h1234_5700, 32'd55, 0, 0, 0, 0, 1));
        items_to_send.push_back(directed_item(0, 32'h1234_5800, 32'd66, 0, 0, 0, 0, 1));
        // Set done reloads the previous count and releases the held values.
        items_to_send.push_back(directed_item(0, 32'h0000_0000, 32'd77, 1, 0, 0, 0, 1));
        // Drop out of operation, then come back with reloaded previous counts.
        it = random_item(0);
        it.operational = 1'b0;
        items_to_send.push_back(it);
        items_to_send.push_back(directed_item(0, 32'hFFFF_FFFF, 32'h3, 0, 0, 0, 0, 0));
        items_to_send.push_back(directed_item(1, 32'h0000_0005, 32'h6, 0, 0, 0, 0, 0));
        items_to_send.push_back(directed_item(0, 32'h0000_0003, 32'h7, 0, 0, 0, 0, 0));
        // Largest single step wraps the count to its most positive value.
        items_to_send.push_back(directed_item(1, 32'h8000_0005, 32'h8, 0, 0, 0, 0, 0));
        // Count reset masks an index edge in the same item.
        items_to_send.push_back(directed_item(1, 32'h8000_0006, 32'h9, 0, 1, 1, 1, 0));
        items_to_send.push_back(directed_item(1, 32'h8000_0007, 32'hA, 0, 0, 1, 0, 0));
        items_to_send.push_back(directed_item(1, 32'h8000_0009, 32'hB, 0, 1, 1, 0, 0));
        wait_idle();

        // Random phases, each with its own gains; the idle pattern changes every two phases.
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin pg = 32'h8000_0000; qg = 32'hFFFF_FFFF; end
                1: begin pg = 32'h7FFF_FFFF; qg = 32'h0000_0000; end
                2: begin pg = 32'h0000_0000; qg = 32'h0000_0001; end
                3: begin pg = $urandom;      qg = $urandom;      end
                4: begin pg = 32'h0001_0000; qg = 32'h0000_FFFF; end
                default: begin pg = 32'hFFFF_0000; qg = $urandom; end
            endcase
            send_idle_pct = (p < 2) ? 8 : (p < 4) ? 61 : 0;
            recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 8 : 0;
            write_reg(ectk_pkg::REG_POSITION_GAIN, pg);
            write_reg(ectk_pkg::REG_PERIOD_GAIN, qg);
            if (p == 4)
                hold_go = 1'b1;

            // Mostly full bus cycles (both channels in order), with stray items and dropouts.
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ($urandom_range(49) == 0)
                begin
                    it = random_item($urandom_range(1));
                    it.operational = 1'b0;
                    items_to_send.push_back(it);
                    count++;
                end
                else if ($urandom_range(4) != 0)
                begin
                    items_to_send.push_back(random_item(0));
                    items_to_send.push_back(random_item(1));
                    count += 2;
                end
                else
                begin
                    items_to_send.push_back(random_item($urandom_range(1)));
                    count++;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== encoder_count_tracker_index.f =====
rtl/core/ectk_pkg.sv
rtl/core/ectk_if.sv
rtl/core/ectk_state_mem.sv
rtl/core/ectk_update.sv
rtl/core/ectk_scale.sv
rtl/core/encoder_count_tracker_index.sv
tb/tb_top.sv
